FILE: rtl/core/dgv_pkg.sv
`default_nettype none

package dgv_pkg;

    // One input word: evaluation time and position.
    typedef struct packed {
        logic        [31:0] time_req;
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
    } t_in_word;

    // One output word: velocity components.
    typedef struct packed {
        logic signed [31:0] vel_x;
        logic signed [31:0] vel_y;
    } t_out_word;

    // Configuration register indexes.
    localparam int CFG_IDX_W = 2;
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_AMPLITUDE    = 2'd0,
        CFG_PERTURBATION = 2'd1,
        CFG_ANGULAR_RATE = 2'd2,
        CFG_DIRECTION    = 2'd3
    } t_cfg_idx;

    localparam logic signed [31:0] AMPLITUDE_RST    = 32'sd26843546;
    localparam logic signed [31:0] PERTURBATION_RST = 32'sd67108864;
    localparam logic signed [31:0] ANGULAR_RATE_RST = 32'sd10541435;

    // CORDIC start value (inverse gain, Q1.30) and the clamp limit.
    localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;
    localparam logic signed [31:0] ONE_Q30     = 32'sd1073741824;

    // Phase reduction constants: 2*pi in Q.40, a slightly low reciprocal
    // for the quotient estimate (2^72 / 2*pi*2^40), and 2^32 / 2*pi.
    localparam logic [42:0] TWO_PI_Q40       = 43'd6908435304715;
    localparam logic [29:0] RECIP_TWO_PI_Q72 = 30'd683565274;
    localparam logic [29:0] INV_TWO_PI_Q32   = 30'd683565276;
    localparam int          PHASE_LAT        = 6;

    localparam logic signed [31:0] PI_Q29  = 32'sd1686629713;
    localparam logic signed [33:0] ONE_Q28 = 34'sd268435456;

    // Arctangent of 2^-step in binary-angle units (2^32 is one turn).
    function automatic logic [31:0] atan_angle(input int unsigned step);
        logic [31:0] v;
        case (step)
            0:  v = 32'h20000000;
            1:  v = 32'h12E4051E;
            2:  v = 32'h09FB385B;
            3:  v = 32'h051111D4;
            4:  v = 32'h028B0D43;
            5:  v = 32'h0145D7E1;
            6:  v = 32'h00A2F61E;
            7:  v = 32'h00517C55;
            8:  v = 32'h0028BE53;
            9:  v = 32'h00145F2F;
            10: v = 32'h000A2F98;
            11: v = 32'h000517CC;
            12: v = 32'h00028BE6;
            13: v = 32'h000145F3;
            14: v = 32'h0000A2FA;
            15: v = 32'h0000517D;
            16: v = 32'h000028BE;
            17: v = 32'h0000145F;
            18: v = 32'h00000A30;
            19: v = 32'h00000518;
            20: v = 32'h0000028C;
            21: v = 32'h00000146;
            22: v = 32'h000000A3;
            23: v = 32'h00000051;
            24: v = 32'h00000029;
            25: v = 32'h00000014;
            26: v = 32'h0000000A;
            27: v = 32'h00000005;
            28: v = 32'h00000003;
            29: v = 32'h00000001;
            30: v = 32'h00000001;
            default: v = 32'h00000000;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

FILE: rtl/core/dgv_cordic.sv
`default_nettype none

// Pipelined rotation-mode CORDIC, one micro-rotation per stage, then a
// registered quadrant mapping; all stages advance together on i_en.
module dgv_cordic
    import dgv_pkg::*;
#(
    parameter int STEPS = 24
) (
    input  wire logic               i_clk,
    input  wire logic               i_en,
    input  wire logic        [31:0] i_angle,
    output logic signed      [31:0] o_cos,
    output logic signed      [31:0] o_sin
);

    logic signed [33:0] r_x [STEPS];
    logic signed [33:0] r_y [STEPS];
    logic signed [31:0] r_z [STEPS];
    logic        [1:0]  r_q [STEPS];

    function automatic logic signed [31:0] clamp30(input logic signed [33:0] v);
        logic signed [31:0] c;
        if (v > 34'sd1073741824) begin
            c = ONE_Q30;
        end else if (v < -34'sd1073741824) begin
            c = -ONE_Q30;
        end else begin
            c = v[31:0];
        end
        return c;
    endfunction

    for (genvar i = 0; i < STEPS; i++) begin : g_step
        logic signed [33:0] w_x;
        logic signed [33:0] w_y;
        logic signed [31:0] w_z;
        logic signed [31:0] w_atan;
        logic        [1:0]  w_q;

        if (i == 0) begin : g_first
            assign w_x = CORDIC_GAIN;
            assign w_y = '0;
            assign w_z = signed'({2'b00, i_angle[29:0]});
            assign w_q = i_angle[31:30];
        end else begin : g_next
            assign w_x = r_x[i-1];
            assign w_y = r_y[i-1];
            assign w_z = r_z[i-1];
            assign w_q = r_q[i-1];
        end

        assign w_atan = signed'(atan_angle(i));

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                if (w_z >= 0) begin
                    r_x[i] <= w_x - (w_y >>> i);
                    r_y[i] <= w_y + (w_x >>> i);
                    r_z[i] <= w_z - w_atan;
                end else begin
                    r_x[i] <= w_x + (w_y >>> i);
                    r_y[i] <= w_y - (w_x >>> i);
                    r_z[i] <= w_z + w_atan;
                end
                r_q[i] <= w_q;
            end
        end
    end

    logic signed [31:0] w_cx;
    logic signed [31:0] w_sy;

    assign w_cx = clamp30(r_x[STEPS-1]);
    assign w_sy = clamp30(r_y[STEPS-1]);

    // Map the first-quadrant result to the quadrant of the angle.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            case (r_q[STEPS-1])
                2'd0: begin
                    o_cos <= w_cx;
                    o_sin <= w_sy;
                end
                2'd1: begin
                    o_cos <= -w_sy;
                    o_sin <= w_cx;
                end
                2'd2: begin
                    o_cos <= -w_cx;
                    o_sin <= -w_sy;
                end
                default: begin
                    o_cos <= w_sy;
                    o_sin <= -w_cx;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

FILE: rtl/core/dgv_phase.sv
`default_nettype none

// Forcing phase: |omega| * t reduced modulo 2*pi, scaled to a binary angle
// and negated for a negative rate. Six register stages; the modulo uses a
// reciprocal quotient estimate, a back-multiply and one final correction.
module dgv_phase
    import dgv_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_en,
    input  wire logic        [31:0] i_time,
    input  wire logic signed [31:0] i_rate,
    output logic             [31:0] o_angle
);

    localparam logic [44:0] M1 = 45'(TWO_PI_Q40);
    localparam logic [44:0] M2 = 45'(TWO_PI_Q40) << 1;

    logic [31:0] w_rate_mag;
    logic [63:0] r_p;
    logic [63:0] r_p2;
    logic [63:0] r_p3;
    logic [60:0] w_qp;
    logic [20:0] r_qe;
    logic [63:0] w_prod;
    logic [63:0] r_prod;
    logic [63:0] w_r0;
    logic [44:0] r_r0;
    logic [44:0] w_r;
    logic [42:0] r_r;
    logic [60:0] w_ap;
    logic [31:0] w_ang;

    assign w_rate_mag = i_rate[31] ? (~i_rate + 32'd1) : i_rate;
    assign w_qp       = 61'(r_p[62:32]) * 61'(RECIP_TWO_PI_Q72);
    assign w_prod     = 64'(r_qe) * 64'(TWO_PI_Q40);
    assign w_r0       = r_p3 - r_prod;
    assign w_r        = (r_r0 >= M2) ? (r_r0 - M2) :
                        (r_r0 >= M1) ? (r_r0 - M1) : r_r0;
    assign w_ap       = 61'(r_r[42:12]) * 61'(INV_TWO_PI_Q32);
    assign w_ang      = w_ap[59:28];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p     <= 64'(w_rate_mag) * 64'(i_time);
            r_qe    <= w_qp[60:40];
            r_p2    <= r_p;
            r_prod  <= w_prod;
            r_p3    <= r_p2;
            r_r0    <= w_r0[44:0];
            r_r     <= w_r[42:0];
            o_angle <= i_rate[31] ? (~w_ang + 32'd1) : w_ang;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/core/double_gyre_velocity_field_unit.sv
`default_nettype none

// Double-gyre velocity unit. Each input word carries a time (unsigned Q16.16)
// and a position (signed Q4.28); each output word carries the velocity
// (u, v) of the time-periodic double-gyre flow at that point, signed Q4.28 and
// saturated. The block is a fully pipelined datapath: it accepts one word per
// clock while no finished word is stalled and returns results in order. The
// depth is set by the two CORDIC pipelines (one for sin(omega*t), one pair
// for the angles pi*f and pi*y), each CORDIC_STEPS + 1 stages deep, plus six
// stages of phase reduction, three for the f polynomial and four for the
// products and saturation. Every stage advances whenever the output register
// is empty or being read, so the input is refused only while a finished word
// waits at the output. Amplitude, perturbation, angular rate and direction are
// plain write-only registers; write them only while no word is in flight.
module double_gyre_velocity_field_unit
    import dgv_pkg::*;
#(
    parameter int CORDIC_STEPS = 24
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_in_valid,
    output logic                      o_in_ready,
    input  wire t_in_word             i_in_word,
    output logic                      o_out_valid,
    input  wire logic                 i_out_ready,
    output t_out_word                 o_out_word,
    input  wire logic                 i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [31:0]          i_cfg_data
);

    // D1: input to sin(omega*t); D2: depth of the second CORDIC bank.
    localparam int D1  = PHASE_LAT + CORDIC_STEPS + 1;
    localparam int D2  = CORDIC_STEPS + 1;
    localparam int LAT = D1 + 3 + D2 + 4;

    // Configuration registers.
    logic signed [31:0] r_amp;
    logic signed [31:0] r_eps;
    logic signed [31:0] r_rate;
    logic               r_dir;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_amp  <= AMPLITUDE_RST;
            r_eps  <= PERTURBATION_RST;
            r_rate <= ANGULAR_RATE_RST;
            r_dir  <= 1'b0;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_AMPLITUDE:    r_amp  <= i_cfg_data;
                CFG_PERTURBATION: r_eps  <= i_cfg_data;
                CFG_ANGULAR_RATE: r_rate <= i_cfg_data;
                CFG_DIRECTION:    r_dir  <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // pi*A depends only on configuration, so it is refreshed every cycle.
    logic signed [63:0] w_pap;
    logic signed [33:0] r_pa;

    assign w_pap = PI_Q29 * r_amp;

    always_ff @(posedge i_clk) begin
        r_pa <= w_pap[62:29];
    end

    // Pipeline advance: the whole pipe moves unless a finished word is stalled.
    logic           w_en;
    logic [LAT-1:0] r_vld;

    assign w_en        = !r_vld[LAT-1] || i_out_ready;
    assign o_in_ready  = w_en;
    assign o_out_valid = r_vld[LAT-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[LAT-2:0], i_in_valid};
        end
    end

    // Phase reduction and the first CORDIC give sin(omega*t).
    logic        [31:0] w_phase;
    logic signed [31:0] w_cw;
    logic signed [31:0] w_sw;

    dgv_phase u_phase (
        .i_clk   (i_clk),
        .i_en    (w_en),
        .i_time  (i_in_word.time_req),
        .i_rate  (r_rate),
        .o_angle (w_phase)
    );

    dgv_cordic #(.STEPS(CORDIC_STEPS)) u_cordic_w (
        .i_clk   (i_clk),
        .i_en    (w_en),
        .i_angle (w_phase),
        .o_cos   (w_cw),
        .o_sin   (w_sw)
    );

    // Position travels alongside the phase pipeline.
    logic signed [31:0] r_xd [D1];
    logic signed [31:0] r_yd [D1];

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_xd[0] <= i_in_word.pos_x;
            r_yd[0] <= i_in_word.pos_y;
            for (int k = 1; k < D1; k++) begin
                r_xd[k] <= r_xd[k-1];
                r_yd[k] <= r_yd[k-1];
            end
        end
    end

    // Stage A: es = eps*sin >> 30 and x^2 >> 28.
    logic signed [63:0] w_a_esp;
    logic signed [63:0] w_a_xxp;
    logic signed [32:0] r_a_es;
    logic signed [35:0] r_a_xx;
    logic signed [31:0] r_a_x;
    logic signed [31:0] r_a_y;

    assign w_a_esp = r_eps * w_sw;
    assign w_a_xxp = r_xd[D1-1] * r_xd[D1-1];

    // Stage B: the three products of f and dfdx. Only the low 29 bits of f
    // matter, because pi*f is taken modulo one turn.
    logic signed [33:0] w_b_k;
    logic signed [68:0] w_b_t1p;
    logic signed [65:0] w_b_t2p;
    logic signed [64:0] w_b_t3p;
    logic        [28:0] r_b_t1;
    logic        [28:0] r_b_t2;
    logic signed [37:0] r_b_t3;
    logic signed [33:0] r_b_k;
    logic signed [31:0] r_b_y;

    assign w_b_k   = ONE_Q28 - signed'({r_a_es, 1'b0});
    assign w_b_t1p = r_a_xx * r_a_es;
    assign w_b_t2p = w_b_k * r_a_x;
    assign w_b_t3p = r_a_es * r_a_x;

    // Stage C: angles for pi*f and pi*y, and dfdx.
    logic        [28:0] w_c_f;
    logic        [31:0] r_c_fang;
    logic        [31:0] r_c_yang;
    logic signed [37:0] r_c_dfdx;

    assign w_c_f = r_b_t1 + r_b_t2;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_a_es   <= w_a_esp[62:30];
            r_a_xx   <= w_a_xxp[63:28];
            r_a_x    <= r_xd[D1-1];
            r_a_y    <= r_yd[D1-1];
            r_b_t1   <= w_b_t1p[56:28];
            r_b_t2   <= w_b_t2p[56:28];
            r_b_t3   <= w_b_t3p[64:27];
            r_b_k    <= w_b_k;
            r_b_y    <= r_a_y;
            r_c_fang <= {w_c_f, 3'b000};
            r_c_yang <= {r_b_y[28:0], 3'b000};
            r_c_dfdx <= r_b_t3 + 38'(r_b_k);
        end
    end

    // Second CORDIC bank: sin/cos of pi*f and pi*y in parallel.
    logic signed [31:0] w_cf;
    logic signed [31:0] w_sf;
    logic signed [31:0] w_cy;
    logic signed [31:0] w_sy;

    dgv_cordic #(.STEPS(CORDIC_STEPS)) u_cordic_f (
        .i_clk   (i_clk),
        .i_en    (w_en),
        .i_angle (r_c_fang),
        .o_cos   (w_cf),
        .o_sin   (w_sf)
    );

    dgv_cordic #(.STEPS(CORDIC_STEPS)) u_cordic_y (
        .i_clk   (i_clk),
        .i_en    (w_en),
        .i_angle (r_c_yang),
        .o_cos   (w_cy),
        .o_sin   (w_sy)
    );

    logic signed [37:0] r_dd [D2];

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_dd[0] <= r_c_dfdx;
            for (int k = 1; k < D2; k++) begin
                r_dd[k] <= r_dd[k-1];
            end
        end
    end

    // Stages D to F: the product chains for u and v, at most one multiply per stage.
    logic signed [65:0] w_d_up;
    logic signed [65:0] w_d_vp;
    logic signed [34:0] r_d_u1;
    logic signed [34:0] r_d_v1;
    logic signed [31:0] r_d_cy;
    logic signed [31:0] r_d_sy;
    logic signed [37:0] r_d_dfdx;
    logic signed [66:0] w_e_up;
    logic signed [66:0] w_e_vp;
    logic signed [35:0] r_e_u2;
    logic signed [35:0] r_e_v2;
    logic signed [37:0] r_e_dfdx;
    logic signed [73:0] w_f_vp;
    logic signed [35:0] r_f_u2;
    logic signed [45:0] r_f_v3;

    assign w_d_up = r_pa * w_sf;
    assign w_d_vp = r_pa * w_cf;
    assign w_e_up = r_d_u1 * r_d_cy;
    assign w_e_vp = r_d_v1 * r_d_sy;
    assign w_f_vp = r_e_v2 * r_e_dfdx;

    // Stage G: apply the time direction and saturate into the output word.
    logic signed [36:0] w_g_u;
    logic signed [46:0] w_g_v;

    assign w_g_u = r_dir ? 37'(r_f_u2) : -37'(r_f_u2);
    assign w_g_v = r_dir ? -47'(r_f_v3) : 47'(r_f_v3);

    function automatic logic signed [31:0] sat32(input logic signed [46:0] v);
        logic signed [31:0] s;
        if (v > 47'sd2147483647) begin
            s = 32'sh7FFFFFFF;
        end else if (v < -47'sd2147483648) begin
            s = 32'sh80000000;
        end else begin
            s = v[31:0];
        end
        return s;
    endfunction

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_d_u1           <= w_d_up[64:30];
            r_d_v1           <= w_d_vp[64:30];
            r_d_cy           <= w_cy;
            r_d_sy           <= w_sy;
            r_d_dfdx         <= r_dd[D2-1];
            r_e_u2           <= w_e_up[65:30];
            r_e_v2           <= w_e_vp[65:30];
            r_e_dfdx         <= r_d_dfdx;
            r_f_u2           <= r_e_u2;
            r_f_v3           <= w_f_vp[73:28];
            o_out_word.vel_x <= sat32(47'(w_g_u));
            o_out_word.vel_y <= sat32(w_g_v);
        end
    end

    // The cosine of the forcing phase is not needed by the flow equations.
    logic w_cw_unused;
    assign w_cw_unused = ^w_cw;

    // While the pipe is stalled, no word moves or vanishes.
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_en |=> $stable(r_vld))
        else $error("pipeline valid bits moved during a stall");

    // An accepted word enters the first stage.
    a_accept_enters: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> r_vld[0])
        else $error("accepted word did not enter the pipeline");

    // A word appears at the output only if the last internal stage held one.
    a_no_invent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_en && !r_vld[LAT-2]) |=> !o_out_valid)
        else $error("output word appeared from an empty stage");

    // With the output empty, the block never refuses input.
    a_empty_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_out_valid |-> o_in_ready)
        else $error("input refused while output register is empty");

    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

endmodule

`default_nettype wire
